[hw/rtl/usc_pkg.sv]
package usc_pkg;

  // Default sizes
  localparam int DEF_TABLE_ENTRIES    = 32;
  localparam int DEF_MAX_SUFFIX_CHARS = 10;

  // Suffix key: ten character slots, first character in the top byte
  localparam int KEY_CHARS = 10;
  localparam int KEY_W     = KEY_CHARS * 8;
  localparam int LEN_W     = 4;
  localparam int CNT_W     = 4;

  // Port widths
  localparam int IN_TDATA_W  = 96;
  localparam int OUT_TDATA_W = 8;

  // Input item kinds
  localparam logic [1:0] KIND_BYTE   = 2'd0;
  localparam logic [1:0] KIND_INSERT = 2'd1;
  localparam logic [1:0] KIND_CLEAR  = 2'd2;

  // Commands passed from front to back
  localparam logic [1:0] OP_CLEAR  = 2'd0;
  localparam logic [1:0] OP_INSERT = 2'd1;
  localparam logic [1:0] OP_LOOKUP = 2'd2;

  // Delimiter tracking
  localparam logic [1:0] DELIM_NONE = 2'd0;
  localparam logic [1:0] DELIM_DOT  = 2'd1;
  localparam logic [1:0] DELIM_PATH = 2'd2;

  // Insert status codes
  localparam logic [1:0] ST_INSERTED = 2'd0;
  localparam logic [1:0] ST_DUP      = 2'd1;
  localparam logic [1:0] ST_FULL     = 2'd2;

  // Result kinds
  localparam logic RK_LOOKUP = 1'b0;
  localparam logic RK_INSERT = 1'b1;

  // Characters of interest
  localparam logic [7:0] CHAR_DOT   = 8'h2E;
  localparam logic [7:0] CHAR_SLASH = 8'h2F;
  localparam logic [7:0] CHAR_QMARK = 8'h3F;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [LEN_W-1:0] len;
  } ent_t;

  typedef struct packed {
    logic [1:0] op;
    ent_t       ent;
  } cmd_t;

  // ASCII upper case to lower case, other bytes untouched
  function automatic logic [7:0] fold_char(input logic [7:0] c);
    logic [7:0] r;
    r = c;
    if (c >= 8'h41 && c <= 8'h5A) begin
      r = c + 8'h20;
    end
    return r;
  endfunction

endpackage

[hw/rtl/usc_front.sv]
module usc_front
  import usc_pkg::*;
#(
  parameter int MAX_SUFFIX_CHARS = DEF_MAX_SUFFIX_CHARS
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [1:0]       kind,
  input  logic [7:0]       url_byte,
  input  logic             url_last,
  input  logic [39:0]      chars_front,
  input  logic [39:0]      chars_back,
  input  logic [LEN_W-1:0] entry_len,
  output logic             push_valid,
  input  logic             push_ready,
  output cmd_t             push_cmd
);

  localparam int TAIL_W = MAX_SUFFIX_CHARS * 8;

  // URL stream state; tail holds the newest character in the low byte
  logic [TAIL_W-1:0] tail_r, tail_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [1:0]        delim_r, delim_nxt;
  logic [7:0]        prev_r, prev_nxt;
  logic              path_r, path_nxt;
  logic              first_r, first_nxt;

  logic              accept;
  logic              is_delim;
  logic [TAIL_W-1:0] tail_upd;
  logic [CNT_W-1:0]  cnt_upd;
  logic [1:0]        delim_upd;
  logic              path_upd;
  logic              hit_ok;
  logic [6:0]        shamt;
  logic [TAIL_W-1:0] tail_sh;
  logic [KEY_W-1:0]  raw_key;
  logic [KEY_W-1:0]  look_key;
  logic [KEY_W-1:0]  ins_raw;
  logic [KEY_W-1:0]  ins_key;
  logic              ins_ok;

  assign in_ready = push_ready;
  assign accept   = in_valid & in_ready;

  // Per-byte update of the stream state
  always_comb begin
    is_delim = (url_byte == CHAR_DOT) || (url_byte == CHAR_SLASH) ||
               (url_byte == CHAR_QMARK);
    path_upd = path_r | (~first_r & ((prev_r == CHAR_QMARK) ||
               ((prev_r == CHAR_SLASH) && (url_byte != CHAR_SLASH))));
    delim_upd = delim_r;
    cnt_upd   = cnt_r;
    if (!first_r && is_delim) begin
      delim_upd = (url_byte == CHAR_DOT) ? DELIM_DOT : DELIM_PATH;
      cnt_upd   = '0;
    end else if (cnt_r < CNT_W'(MAX_SUFFIX_CHARS + 1)) begin
      cnt_upd = cnt_r + CNT_W'(1);
    end
    tail_upd = (tail_r << 8) | TAIL_W'(url_byte);
    hit_ok   = ~first_r & path_upd & (delim_upd == DELIM_DOT) &
               (cnt_upd != '0) & (cnt_upd <= CNT_W'(MAX_SUFFIX_CHARS));
  end

  // Align the characters after the dot to the top of the key, fold case
  always_comb begin
    shamt    = (7'(MAX_SUFFIX_CHARS) - 7'(cnt_upd)) << 3;
    tail_sh  = tail_upd << shamt;
    raw_key  = KEY_W'(tail_sh) << (KEY_W - TAIL_W);
    look_key = '0;
    for (int k = 0; k < KEY_CHARS; k++) begin
      look_key[KEY_W-1-8*k -: 8] = fold_char(raw_key[KEY_W-1-8*k -: 8]);
    end
  end

  // Insert key: folded, characters past the length zeroed
  always_comb begin
    ins_ok  = (entry_len != '0) && (entry_len <= LEN_W'(MAX_SUFFIX_CHARS));
    ins_raw = {chars_front, chars_back};
    ins_key = '0;
    for (int k = 0; k < KEY_CHARS; k++) begin
      if (LEN_W'(k) < entry_len) begin
        ins_key[KEY_W-1-8*k -: 8] = fold_char(ins_raw[KEY_W-1-8*k -: 8]);
      end
    end
  end

  // Item decode
  always_comb begin
    tail_nxt   = tail_r;
    cnt_nxt    = cnt_r;
    delim_nxt  = delim_r;
    prev_nxt   = prev_r;
    path_nxt   = path_r;
    first_nxt  = first_r;
    push_valid = 1'b0;
    push_cmd   = '0;
    if (accept) begin
      unique case (kind)
        KIND_BYTE: begin
          if (url_last) begin
            push_valid       = 1'b1;
            push_cmd.op      = OP_LOOKUP;
            push_cmd.ent.key = look_key;
            push_cmd.ent.len = hit_ok ? LEN_W'(cnt_upd) : '0;
            tail_nxt         = '0;
            cnt_nxt          = '0;
            delim_nxt        = DELIM_NONE;
            prev_nxt         = '0;
            path_nxt         = 1'b0;
            first_nxt        = 1'b1;
          end else begin
            tail_nxt  = tail_upd;
            cnt_nxt   = cnt_upd;
            delim_nxt = delim_upd;
            prev_nxt  = url_byte;
            path_nxt  = path_upd;
            first_nxt = 1'b0;
          end
        end
        KIND_INSERT: begin
          if (ins_ok) begin
            push_valid       = 1'b1;
            push_cmd.op      = OP_INSERT;
            push_cmd.ent.key = ins_key;
            push_cmd.ent.len = entry_len;
          end
        end
        KIND_CLEAR: begin
          push_valid  = 1'b1;
          push_cmd.op = OP_CLEAR;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tail_r  <= '0;
      cnt_r   <= '0;
      delim_r <= DELIM_NONE;
      prev_r  <= '0;
      path_r  <= 1'b0;
      first_r <= 1'b1;
    end else begin
      tail_r  <= tail_nxt;
      cnt_r   <= cnt_nxt;
      delim_r <= delim_nxt;
      prev_r  <= prev_nxt;
      path_r  <= path_nxt;
      first_r <= first_nxt;
    end
  end

endmodule

[hw/rtl/usc_cmd_queue.sv]
module usc_cmd_queue
  import usc_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push_valid,
  output logic push_ready,
  input  cmd_t push_cmd,
  output logic pop_valid,
  input  logic pop_ready,
  output cmd_t pop_cmd
);

  // Two-entry queue between front and back
  cmd_t       slot_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] fill_r, fill_nxt;
  logic       do_push, do_pop;

  assign push_ready = (fill_r != 2'd2);
  assign pop_valid  = (fill_r != 2'd0);
  assign pop_cmd    = slot_r[rd_ptr_r];
  assign do_push    = push_valid & push_ready;
  assign do_pop     = pop_valid & pop_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r ^ do_push;
    rd_ptr_nxt = rd_ptr_r ^ do_pop;
    fill_nxt   = fill_r + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      fill_r   <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  // Payload, no reset
  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

[hw/rtl/usc_back.sv]
module usc_back
  import usc_pkg::*;
#(
  parameter int TABLE_ENTRIES = DEF_TABLE_ENTRIES
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cmd_valid,
  output logic       cmd_ready,
  input  cmd_t       cmd,
  output logic       res_valid,
  input  logic       res_ready,
  output logic       res_kind,
  output logic       res_hit,
  output logic [1:0] res_status
);

  localparam int AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CW = $clog2(TABLE_ENTRIES + 1);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_DONE = 2'd2;

  logic [1:0]    state_r, state_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [CW-1:0] issue_r, issue_nxt;
  logic          rd_vld_r, rd_vld_nxt;
  logic          hit_r, hit_nxt;
  cmd_t          cmd_r, cmd_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic          out_kind_r, out_kind_nxt;
  logic          out_hit_r, out_hit_nxt;
  logic [1:0]    out_status_r, out_status_nxt;

  // Suffix table
  ent_t          mem [TABLE_ENTRIES];
  ent_t          rd_data_r;
  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic          match;

  assign res_valid  = out_valid_r;
  assign res_kind   = out_kind_r;
  assign res_hit    = out_hit_r;
  assign res_status = out_status_r;

  assign match = rd_vld_r && (rd_data_r == cmd_r.ent);

  // Sequencer: pop a command; a clear empties the table, others sweep the table and post the result
  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    issue_nxt      = issue_r;
    rd_vld_nxt     = 1'b0;
    hit_nxt        = hit_r;
    cmd_nxt        = cmd_r;
    out_valid_nxt  = out_valid_r & ~res_ready;
    out_kind_nxt   = out_kind_r;
    out_hit_nxt    = out_hit_r;
    out_status_nxt = out_status_r;
    cmd_ready      = 1'b0;
    rd_en          = 1'b0;
    rd_addr        = issue_r[AW-1:0];
    wr_en          = 1'b0;
    wr_addr        = count_r[AW-1:0];
    unique case (state_r)
      S_IDLE: begin
        cmd_ready = 1'b1;
        if (cmd_valid) begin
          if (cmd.op == OP_CLEAR) begin
            count_nxt = '0;
          end else begin
            cmd_nxt   = cmd;
            issue_nxt = '0;
            hit_nxt   = 1'b0;
            state_nxt = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (issue_r < count_r) begin
          rd_en      = 1'b1;
          issue_nxt  = issue_r + CW'(1);
          rd_vld_nxt = 1'b1;
        end
        if (match) begin
          hit_nxt = 1'b1;
        end
        if ((issue_r == count_r) && !rd_vld_r) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_r || res_ready) begin
          out_valid_nxt  = 1'b1;
          out_hit_nxt    = 1'b0;
          out_status_nxt = ST_INSERTED;
          if (cmd_r.op == OP_INSERT) begin
            out_kind_nxt = RK_INSERT;
            if (hit_r) begin
              out_status_nxt = ST_DUP;
            end else if (count_r >= CW'(TABLE_ENTRIES)) begin
              out_status_nxt = ST_FULL;
            end else begin
              wr_en     = 1'b1;
              count_nxt = count_r + CW'(1);
            end
          end else begin
            out_kind_nxt = RK_LOOKUP;
            out_hit_nxt  = hit_r;
          end
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      issue_r     <= '0;
      rd_vld_r    <= 1'b0;
      hit_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      issue_r     <= issue_nxt;
      rd_vld_r    <= rd_vld_nxt;
      hit_r       <= hit_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    cmd_r        <= cmd_nxt;
    out_kind_r   <= out_kind_nxt;
    out_hit_r    <= out_hit_nxt;
    out_status_r <= out_status_nxt;
  end

  // Table memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= cmd_r.ent;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

endmodule

[hw/rtl/url_suffix_classifier.sv]
// Non-final URL bytes: one transaction per cycle while the command queue has
// room, no result. Final byte or insert of a valid length: out_tvalid is set
// after a sweep of the suffix table, one entry per cycle through its single
// read port. Clear: empties the table in the back end, no result. A two-entry
// queue lets bytes keep arriving while the back end sweeps. Reset (rst_n low,
// synchronous) empties the table and returns the URL state to a URL start.
module url_suffix_classifier
  import usc_pkg::*;
#(
  parameter int TABLE_ENTRIES    = DEF_TABLE_ENTRIES,
  parameter int MAX_SUFFIX_CHARS = DEF_MAX_SUFFIX_CHARS
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // url_byte[7:0], entry_chars_front[47:8], entry_chars_back[87:48],
  // entry_length[91:88], zero pad
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  input  logic [1:0]             in_tuser,   // kind
  input  logic                   in_tlast,   // url_last
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // is_download[0], insert_status[2:1], zero pad
  output logic [OUT_TDATA_W-1:0] out_tdata,
  output logic                   out_tuser   // result_kind
);

  logic       q_push_valid, q_push_ready;
  cmd_t       q_push_cmd;
  logic       q_pop_valid, q_pop_ready;
  cmd_t       q_pop_cmd;
  logic       res_hit;
  logic [1:0] res_status;

  usc_front #(
    .MAX_SUFFIX_CHARS(MAX_SUFFIX_CHARS)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .kind       (in_tuser),
    .url_byte   (in_tdata[7:0]),
    .url_last   (in_tlast),
    .chars_front(in_tdata[47:8]),
    .chars_back (in_tdata[87:48]),
    .entry_len  (in_tdata[91:88]),
    .push_valid (q_push_valid),
    .push_ready (q_push_ready),
    .push_cmd   (q_push_cmd)
  );

  usc_cmd_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_valid(q_push_valid),
    .push_ready(q_push_ready),
    .push_cmd  (q_push_cmd),
    .pop_valid (q_pop_valid),
    .pop_ready (q_pop_ready),
    .pop_cmd   (q_pop_cmd)
  );

  usc_back #(
    .TABLE_ENTRIES(TABLE_ENTRIES)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (q_pop_valid),
    .cmd_ready (q_pop_ready),
    .cmd       (q_pop_cmd),
    .res_valid (out_tvalid),
    .res_ready (out_tready),
    .res_kind  (out_tuser),
    .res_hit   (res_hit),
    .res_status(res_status)
  );

  assign out_tdata = {5'b0, res_status, res_hit};

  // Front stalls only while the queue holds commands
  a_stall_queued: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> q_pop_valid)
    else $error("input stalled with an empty command queue");

  // An insert status never carries a verdict
  a_ins_no_hit: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == RK_INSERT) |-> !out_tdata[0])
    else $error("insert status with verdict bit set");

  // A verdict never carries an insert status
  a_look_no_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == RK_LOOKUP) |-> (out_tdata[2:1] == ST_INSERTED))
    else $error("verdict with insert status set");

  // No command leaves the queue while a table sweep is still running
  a_push_pop: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop_valid && q_pop_ready && (q_pop_cmd.op != OP_CLEAR) |=> !q_pop_ready)
    else $error("back end took two commands in a row");

endmodule

[test/tb_top.sv]
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import usc_pkg::*;

  localparam int TABLE_SIZE   = 32;
  localparam int SUFFIX_MAX   = 10;
  localparam int POOL_SIZE    = 40;
  localparam int ITEM_TARGET  = 400;
  localparam int STALL_LIMIT  = 4000;
  localparam int DRAIN_CYCLES = 60;
  localparam int HOLD_CYCLES  = 400;

  // kind value the block ignores
  localparam logic [1:0] KIND_UNUSED = 2'd3;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  ch;
    logic        last;
    logic [39:0] front;
    logic [39:0] back;
    logic [3:0]  len;
    logic        drain;   // hold this item back until no result is awaited
  } url_item_t;

  typedef struct packed {
    logic       rk;
    logic       dl;
    logic [1:0] st;
  } result_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;
  logic [1:0]             in_tuser = KIND_BYTE;
  logic                   in_tlast = 1'b0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   out_tuser;

  url_suffix_classifier dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
  end

  // ---------------------------------------------------------------
  // Predictor state: suffix table and URL tracking
  // ---------------------------------------------------------------
  logic [39:0] sfx_front [TABLE_SIZE];
  logic [39:0] sfx_back  [TABLE_SIZE];
  logic [3:0]  sfx_len   [TABLE_SIZE];
  int          sfx_count;
  logic [7:0]  url_tail  [SUFFIX_MAX];
  int          since_delim;
  logic [1:0]  delim_seen;
  logic [7:0]  prev_ch;
  bit          path_found;
  bit          at_url_start;

  url_item_t   queued_items [$];
  result_t     due_results  [$];
  logic [7:0]  url_buf      [$];
  logic [7:0]  pool_ch      [POOL_SIZE][SUFFIX_MAX];
  int          pool_n       [POOL_SIZE];
  int          items_made;
  int          mismatches;
  bit          stim_done;

  function automatic logic [7:0] lower_case(input logic [7:0] c);
    return (c >= 8'h41 && c <= 8'h5A) ? c + 8'h20 : c;
  endfunction

  // character k of a packed key, first character in the top byte of front
  function automatic logic [7:0] key_char(input logic [39:0] f, input logic [39:0] b,
                                          input int k);
    if (k < 5) return f[8*(4-k) +: 8];
    return b[8*(9-k) +: 8];
  endfunction

  function automatic logic [39:0] rand40();
    logic [63:0] w;
    w = {$urandom, $urandom};
    return w[39:0];
  endfunction

  function automatic logic [7:0] rand_case(input logic [7:0] c);
    if (lower_case(c) >= 8'h61 && lower_case(c) <= 8'h7A && $urandom_range(0, 1))
      return c ^ 8'h20;
    return c;
  endfunction

  function automatic logic [7:0] rand_letter();
    return rand_case(8'h61 + 8'($urandom_range(0, 25)));
  endfunction

  // mostly no gap, some short, a few long; none at all in a burst
  function automatic int pick_gap(input bit burst);
    int r;
    r = $urandom_range(0, 99);
    if (burst || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic url_restart();
    for (int k = 0; k < SUFFIX_MAX; k++) url_tail[k] = 8'h00;
    since_delim  = 0;
    delim_seen   = DELIM_NONE;
    prev_ch      = 8'h00;
    path_found   = 1'b0;
    at_url_start = 1'b1;
  endtask

  // Work out the result, if any, of one accepted transaction
  task automatic classify_item(input url_item_t it);
    result_t res;
    bit      hit;
    bit      same;
    int      n;
    res.rk = RK_LOOKUP;
    res.dl = 1'b0;
    res.st = ST_INSERTED;
    case (it.kind)
      KIND_CLEAR: begin
        sfx_count = 0;
      end
      KIND_INSERT: begin
        if (it.len >= 1 && it.len <= SUFFIX_MAX) begin
          res.rk = RK_INSERT;
          for (int j = 0; j < sfx_count; j++) begin
            if (sfx_len[j] == it.len) begin
              same = 1'b1;
              for (int k = 0; k < it.len; k++)
                if (lower_case(key_char(sfx_front[j], sfx_back[j], k)) !=
                    lower_case(key_char(it.front, it.back, k)))
                  same = 1'b0;
              if (same) res.st = ST_DUP;
            end
          end
          if (res.st == ST_INSERTED) begin
            if (sfx_count >= TABLE_SIZE) begin
              res.st = ST_FULL;
            end else begin
              sfx_front[sfx_count] = it.front;
              sfx_back[sfx_count]  = it.back;
              sfx_len[sfx_count]   = it.len;
              sfx_count++;
            end
          end
          due_results.push_back(res);
        end
      end
      KIND_BYTE: begin
        // a delimiter at the very first position counts as an ordinary character
        if (!at_url_start && (prev_ch == CHAR_QMARK ||
                              (prev_ch == CHAR_SLASH && it.ch != CHAR_SLASH)))
          path_found = 1'b1;
        if (!at_url_start && (it.ch == CHAR_DOT || it.ch == CHAR_SLASH ||
                              it.ch == CHAR_QMARK)) begin
          delim_seen  = (it.ch == CHAR_DOT) ? DELIM_DOT : DELIM_PATH;
          since_delim = 0;
        end else if (since_delim < SUFFIX_MAX + 1) begin
          since_delim++;
        end
        for (int k = 0; k < SUFFIX_MAX - 1; k++) url_tail[k] = url_tail[k+1];
        url_tail[SUFFIX_MAX-1] = it.ch;
        prev_ch = it.ch;
        if (!it.last) begin
          at_url_start = 1'b0;
        end else begin
          hit = 1'b0;
          n   = since_delim;
          if (!at_url_start && path_found && delim_seen == DELIM_DOT &&
              n >= 1 && n <= SUFFIX_MAX) begin
            for (int j = 0; j < sfx_count; j++) begin
              if (sfx_len[j] == n) begin
                same = 1'b1;
                for (int k = 0; k < n; k++)
                  if (lower_case(key_char(sfx_front[j], sfx_back[j], k)) !=
                      lower_case(url_tail[SUFFIX_MAX-n+k]))
                    same = 1'b0;
                if (same) hit = 1'b1;
              end
            end
          end
          url_restart();
          res.dl = hit;
          due_results.push_back(res);
        end
      end
      default: ;
    endcase
  endtask

  // ---------------------------------------------------------------
  // Stimulus builders
  // ---------------------------------------------------------------
  task automatic push_item(input logic [1:0] kind, input logic [7:0] ch, input logic last,
                           input logic [39:0] f, input logic [39:0] b,
                           input logic [3:0] len, input logic drain);
    url_item_t it;
    it.kind  = kind;
    it.ch    = ch;
    it.last  = last;
    it.front = f;
    it.back  = b;
    it.len   = len;
    it.drain = drain;
    queued_items.push_back(it);
    items_made++;
  endtask

  task automatic add_str(input string s);
    for (int k = 0; k < s.len(); k++) url_buf.push_back(s[k]);
  endtask

  // send the buffered URL bytes, marking the final one when the URL ends
  task automatic emit_url(input bit close);
    int n;
    n = url_buf.size();
    for (int k = 0; k < n; k++)
      push_item(KIND_BYTE, url_buf[k], close && k == n - 1, rand40(), rand40(),
                4'($urandom), 1'b0);
    url_buf.delete();
  endtask

  // characters past the length are filled with junk
  task automatic insert_str(input string s, input int len);
    logic [39:0] f;
    logic [39:0] b;
    f = rand40();
    b = rand40();
    for (int k = 0; k < s.len() && k < SUFFIX_MAX; k++) begin
      if (k < 5) f[8*(4-k) +: 8] = s[k];
      else b[8*(9-k) +: 8] = s[k];
    end
    push_item(KIND_INSERT, 8'($urandom), 1'($urandom), f, b, 4'(len), 1'b0);
  endtask

  task automatic insert_pool(input int i);
    logic [39:0] f;
    logic [39:0] b;
    f = rand40();
    b = rand40();
    for (int k = 0; k < pool_n[i]; k++) begin
      if (k < 5) f[8*(4-k) +: 8] = rand_case(pool_ch[i][k]);
      else b[8*(9-k) +: 8] = rand_case(pool_ch[i][k]);
    end
    push_item(KIND_INSERT, 8'($urandom), 1'($urandom), f, b, 4'(pool_n[i]), 1'b0);
  endtask

  task automatic push_clear(input logic drain);
    push_item(KIND_CLEAR, 8'($urandom), 1'($urandom), rand40(), rand40(), 4'($urandom),
              drain);
  endtask

  // a plausible URL: optional scheme or leading delimiter, host, path, query, suffix
  task automatic add_random_url();
    int p;
    int i;
    url_buf.delete();
    case ($urandom_range(0, 4))
      0: add_str("/");
      1: add_str("?");
      2: add_str("ab://");
      3: add_str("h/");
      default: ;
    endcase
    repeat ($urandom_range(0, 2)) url_buf.push_back(rand_letter());
    if ($urandom_range(0, 1)) begin
      add_str("/");
      repeat ($urandom_range(0, 2)) url_buf.push_back(rand_letter());
    end
    if ($urandom_range(0, 4) == 0) begin
      add_str("?");
      repeat ($urandom_range(0, 2)) url_buf.push_back(rand_letter());
    end
    // table update in the middle of a URL
    if ($urandom_range(0, 9) == 0) begin
      emit_url(1'b0);
      if ($urandom_range(0, 1)) push_clear(1'b0);
      else insert_pool($urandom_range(0, POOL_SIZE - 1));
    end
    p = $urandom_range(0, 9);
    if (p < 7) begin
      add_str(".");
      i = $urandom_range(0, POOL_SIZE - 1);
      for (int k = 0; k < pool_n[i]; k++) url_buf.push_back(rand_case(pool_ch[i][k]));
    end else if (p < 9) begin
      add_str(".");
      repeat ($urandom_range(1, 12)) url_buf.push_back(8'($urandom_range(8'h21, 8'h7E)));
    end else begin
      url_buf.push_back(rand_letter());
    end
    emit_url(1'b1);
  endtask

  // ---------------------------------------------------------------
  // Driver: one transaction per item from the queue
  // ---------------------------------------------------------------
  url_item_t cur_item;
  int        send_gap;
  bit        send_burst;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) classify_item(cur_item);
      if (!in_tvalid || in_tready) begin
        if (send_gap > 0) begin
          send_gap--;
          in_tvalid <= 1'b0;
        end else if (queued_items.size() == 0) begin
          in_tvalid <= 1'b0;
          stim_done = 1'b1;
        end else if (queued_items[0].drain && due_results.size() != 0) begin
          in_tvalid <= 1'b0;
        end else begin
          cur_item = queued_items.pop_front();
          in_tvalid <= 1'b1;
          in_tdata  <= {{(IN_TDATA_W-92){1'b0}}, cur_item.len, cur_item.back,
                        cur_item.front, cur_item.ch};
          in_tuser  <= cur_item.kind;
          in_tlast  <= cur_item.last;
          send_gap = pick_gap(send_burst);
          if ($urandom_range(0, 39) == 0) send_burst = !send_burst;
        end
      end
    end
  end

  // ---------------------------------------------------------------
  // Receiver: random stalls and one long hold-off
  // ---------------------------------------------------------------
  int recv_wait;
  int inputs_seen;
  bit hold_taken;
  bit recv_burst;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) inputs_seen++;
      if (!hold_taken && inputs_seen >= 120) begin
        hold_taken = 1'b1;
        recv_wait  = HOLD_CYCLES;
      end
      if (recv_wait > 0) begin
        recv_wait--;
        out_tready <= 1'b0;
      end else if (!recv_burst && $urandom_range(0, 3) == 0) begin
        recv_wait = pick_gap(1'b0);
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
      if ($urandom_range(0, 63) == 0) recv_burst = !recv_burst;
    end
  end

  // ---------------------------------------------------------------
  // Monitor: compare each result transaction with the oldest prediction
  // ---------------------------------------------------------------
  result_t want;

  task automatic report_mismatch(input string what, input int got, input int exp_val);
    mismatches++;
    if (mismatches <= 20)
      $display("[%0t] mismatch on %s: got %0d, expected %0d", $realtime, what, got, exp_val);
  endtask

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (due_results.size() == 0) begin
        report_mismatch("result with nothing awaited", out_tuser, 0);
      end else begin
        want = due_results.pop_front();
        if (out_tuser !== want.rk) report_mismatch("result_kind", out_tuser, want.rk);
        if (out_tdata[0] !== want.dl) report_mismatch("is_download", out_tdata[0], want.dl);
        if (out_tdata[2:1] !== want.st)
          report_mismatch("insert_status", out_tdata[2:1], want.st);
      end
    end
  end

  // ---------------------------------------------------------------
  // Watchdog: too long without any transaction on either side
  // ---------------------------------------------------------------
  int quiet_cycles;

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------
  // Stimulus and end of run
  // ---------------------------------------------------------------
  initial begin
    int  p;
    bit  fill_done;
    sfx_count = 0;
    url_restart();

    // distinct suffixes: first two characters encode the index
    for (int i = 0; i < POOL_SIZE; i++) begin
      pool_n[i]     = 1 + i % SUFFIX_MAX;
      pool_ch[i][0] = 8'h61 + 8'(i % 26);
      pool_ch[i][1] = 8'h61 + 8'(i / 26);
      for (int k = 2; k < SUFFIX_MAX; k++)
        pool_ch[i][k] = ($urandom_range(0, 3) == 0) ? 8'h30 + 8'($urandom_range(0, 9))
                                                     : 8'h61 + 8'($urandom_range(0, 25));
    end

    // directed: duplicate by case, bad lengths, ignored kind, longest suffix
    insert_str("zip", 3);
    insert_str("ZIP", 3);
    insert_str("tar", 0);
    insert_str("tar", 15);
    push_item(KIND_UNUSED, 8'hFF, 1'b1, '1, '1, 4'hF, 1'b0);
    insert_str("abcdefghij", 10);
    // slash or question mark at the start, dot right after it
    add_str("/.zip");
    emit_url(1'b1);
    add_str("?.zIp");
    emit_url(1'b1);
    // one-byte URL made of a zero byte
    url_buf.push_back(8'h00);
    emit_url(1'b1);
    // after a clear nothing matches
    push_clear(1'b0);
    add_str("/.zip");
    emit_url(1'b1);

    // random part, with one pass that fills the table past its size
    fill_done = 1'b0;
    while (items_made < ITEM_TARGET) begin
      if (!fill_done && items_made >= 180) begin
        fill_done = 1'b1;
        push_clear(1'b1);
        for (int i = 0; i < TABLE_SIZE + 2; i++) insert_pool(i);
        insert_pool(5);
        repeat (4) add_random_url();
      end
      p = $urandom_range(0, 99);
      if (p < 50) begin
        add_random_url();
      end else if (p < 75) begin
        if ($urandom_range(0, 7) == 0)
          push_item(KIND_INSERT, 8'($urandom), 1'($urandom), rand40(), rand40(),
                    4'($urandom_range(0, 15)), 1'b0);
        else
          insert_pool($urandom_range(0, POOL_SIZE - 1));
      end else if (p < 79) begin
        push_clear(1'b0);
      end else if (p < 82) begin
        push_item(KIND_UNUSED, 8'($urandom), 1'($urandom), rand40(), rand40(),
                  4'($urandom), 1'b0);
      end else begin
        // raw noise: any kind, any byte, random end marks
        repeat ($urandom_range(1, 6))
          push_item(2'($urandom_range(0, 3)), 8'($urandom), $urandom_range(0, 2) == 0,
                    rand40(), rand40(), 4'($urandom), 1'b0);
      end
    end

    wait (stim_done);
    while (due_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

[url_suffix_classifier.f]
hw/rtl/usc_pkg.sv
hw/rtl/usc_front.sv
hw/rtl/usc_cmd_queue.sv
hw/rtl/usc_back.sv
hw/rtl/url_suffix_classifier.sv
test/tb_top.sv
